/* design/kmc_pkg.sv */
// Shared types, codes and constants for the k-means clustering block.
// No dependencies; imported by kmc_cell and kmeans_clustering.
package kmc_pkg;

    localparam int DEF_MAX_POINTS = 1024;
    localparam int DEF_MAX_K      = 8;
    localparam int DEF_MAX_DIM    = 8;

    // Squared distance accumulator: 65-bit squares, up to 64 coordinates.
    localparam int DIST_W = 72;

    localparam logic [1:0] CFG_CLUSTER_COUNT = 2'd0;
    localparam logic [1:0] CFG_DIMENSION     = 2'd1;
    localparam logic [1:0] CFG_MAX_ITER      = 2'd2;
    localparam logic [1:0] CFG_MOVE_THR      = 2'd3;

    localparam logic [3:0]  RST_CLUSTER_COUNT = 4'd2;
    localparam logic [3:0]  RST_DIMENSION     = 4'd2;
    localparam logic [9:0]  RST_MAX_ITER      = 10'd200;
    localparam logic [31:0] RST_MOVE_THR      = 32'd4295;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FEW      = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_SEED,
        OP_CLR,
        OP_DCLR,
        OP_DIST,
        OP_ADD,
        OP_UPD,
        OP_SHIFT
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [5:0]  j;
        logic [5:0]  sel;
        logic [31:0] data;
        logic [6:0]  k;
        logic [31:0] thr;
    } t_cmd;

    typedef struct packed {
        logic              has;
        logic [DIST_W-1:0] dval;
        logic [5:0]        idx;
    } t_best;

    function automatic logic [64:0] sq65(input logic signed [32:0] a);
        logic [32:0] m;
        logic [65:0] p;
        m = a[32] ? 33'(-a) : 33'(a);
        p = 66'(m) * 66'(m);
        return p[64:0];
    endfunction

endpackage

/* design/kmc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module kmc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* design/kmc_cell.sv */
// One centroid cell: coordinates, sums, count, distance, serial divider,
// and one link of the nearest-centroid compare chain. Uses kmc_pkg.
module kmc_cell #(
    parameter int IDX     = 0,
    parameter int MAX_DIM = 8,
    parameter int SUM_W   = 43,
    parameter int CNT_W   = 11
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  kmc_pkg::t_cmd                i_cmd,
    input  kmc_pkg::t_best               i_best,
    output kmc_pkg::t_best               o_best,
    input  logic [MAX_DIM-1:0][31:0]     i_next_cent,
    output logic [MAX_DIM-1:0][31:0]     o_cent,
    output logic                         o_moved
);
    import kmc_pkg::*;

    localparam int DW  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int SCW = $clog2(SUM_W);

    logic [MAX_DIM-1:0][31:0]   r_cent;
    logic signed [SUM_W-1:0]    r_sum [MAX_DIM];
    logic [CNT_W-1:0]           r_cnt;
    logic [DIST_W-1:0]          r_dist;
    logic [DIST_W-1:0]          r_mv;
    logic [64:0]                r_sq;
    logic                       r_sqv_d;
    logic                       r_sqv_m;
    logic                       r_busy;
    logic                       r_fin;
    logic                       r_fin2;
    logic [SCW-1:0]             r_dstep;
    logic [DW-1:0]              r_dj;
    logic                       r_neg;
    logic [SUM_W-1:0]           r_quo;
    logic [CNT_W-1:0]           r_rem;
    logic [31:0]                r_new;
    t_best                      r_best;

    logic [DW-1:0]              cj;
    logic [DW-1:0]              sel_j;
    logic [31:0]                cur;
    logic [31:0]                x;
    logic signed [32:0]         diff;
    logic [64:0]                sq;
    logic                       mine;
    logic                       hit;
    logic [CNT_W:0]             sh;
    logic                       ge;
    logic [CNT_W:0]             sh_sub;
    logic signed [SUM_W-1:0]    s_sel;
    logic [SUM_W-1:0]           mag;
    logic [SUM_W-1:0]           q_s;

    assign cj     = i_cmd.j[DW-1:0];
    assign sel_j  = r_fin2 ? r_dj : cj;
    assign cur    = r_cent[sel_j];
    assign x      = r_fin2 ? r_new : i_cmd.data;
    assign diff   = $signed({x[31], x}) - $signed({cur[31], cur});
    assign sq     = sq65(diff);
    assign mine   = 7'(IDX) < i_cmd.k;
    assign hit    = i_cmd.sel == 6'(IDX);
    assign sh     = {r_rem, r_quo[SUM_W-1]};
    assign ge     = sh >= {1'b0, r_cnt};
    assign sh_sub = sh - {1'b0, r_cnt};
    assign s_sel  = r_sum[cj];
    assign mag    = s_sel[SUM_W-1] ? SUM_W'(-s_sel) : SUM_W'(s_sel);
    assign q_s    = r_neg ? SUM_W'(-r_quo) : r_quo;

    assign o_cent  = r_cent;
    assign o_best  = r_best;
    assign o_moved = r_mv > DIST_W'(i_cmd.thr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sqv_d <= 1'b0;
            r_sqv_m <= 1'b0;
            r_busy  <= 1'b0;
            r_fin   <= 1'b0;
            r_fin2  <= 1'b0;
            r_best  <= '0;
            r_cnt   <= '0;
            r_dist  <= '0;
            r_mv    <= '0;
            for (int d = 0; d < MAX_DIM; d++) begin
                r_sum[d] <= '0;
            end
        end else begin
            r_sqv_d <= 1'b0;
            r_sqv_m <= 1'b0;
            r_fin   <= 1'b0;
            r_fin2  <= 1'b0;

            if (mine && (!i_best.has || r_dist < i_best.dval)) begin
                r_best <= '{has: 1'b1, dval: r_dist, idx: 6'(IDX)};
            end else begin
                r_best <= i_best;
            end

            if (r_sqv_d) begin
                r_dist <= r_dist + DIST_W'(r_sq);
            end
            if (r_sqv_m) begin
                r_mv <= r_mv + DIST_W'(r_sq);
            end

            unique case (i_cmd.op)
                OP_NOP: begin
                end
                OP_SEED: begin
                    if (hit) begin
                        r_cent[cj] <= i_cmd.data;
                    end
                end
                OP_CLR: begin
                    r_cnt <= '0;
                    r_mv  <= '0;
                    for (int d = 0; d < MAX_DIM; d++) begin
                        r_sum[d] <= '0;
                    end
                end
                OP_DCLR: begin
                    r_dist <= '0;
                end
                OP_DIST: begin
                    r_sq    <= sq;
                    r_sqv_d <= 1'b1;
                end
                OP_ADD: begin
                    if (hit) begin
                        r_sum[cj] <= r_sum[cj]
                            + $signed({{(SUM_W-32){i_cmd.data[31]}}, i_cmd.data});
                        if (cj == '0) begin
                            r_cnt <= r_cnt + 1'b1;
                        end
                    end
                end
                OP_UPD: begin
                    if (r_cnt != '0) begin
                        r_busy  <= 1'b1;
                        r_dstep <= '0;
                        r_dj    <= cj;
                        r_neg   <= s_sel[SUM_W-1];
                        r_quo   <= mag;
                        r_rem   <= '0;
                    end
                end
                OP_SHIFT: begin
                    r_cent <= i_next_cent;
                end
            endcase

            if (r_busy) begin
                r_rem   <= ge ? sh_sub[CNT_W-1:0] : sh[CNT_W-1:0];
                r_quo   <= {r_quo[SUM_W-2:0], ge};
                r_dstep <= r_dstep + 1'b1;
                if (r_dstep == SCW'(SUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end
            if (r_fin) begin
                r_new  <= q_s[31:0];
                r_fin2 <= 1'b1;
            end
            if (r_fin2) begin
                r_sq         <= sq;
                r_sqv_m      <= 1'b1;
                r_cent[r_dj] <= r_new;
            end
        end
    end
endmodule

/* design/kmeans_clustering.sv */
// Top level: point store, sequencer and the row of centroid cells.
// Uses kmc_pkg, kmc_ram and kmc_cell.
//
//  channel  | handshake                   | payload
//  ---------+-----------------------------+---------------------------------------
//  in       | i_in_valid / o_in_ready     | i_coordinate, i_last_of_set
//  out      | o_out_valid / i_out_ready   | o_centroid_value .. o_last
//  cfg      | i_cfg_we (write only)       | i_cfg_idx, i_cfg_data
//
// Loading takes one coordinate per cycle into the point RAM.
// After the final coordinate: seeding from the first k points, then per round
// and point a RAM read per coordinate, distances and the compare chain,
// plus a per-coordinate serial division of the sums per round.
// Results leave one per cycle while the output is not stalled; each cluster change inserts a shift of the centroids.
// Reset is synchronous; an output stall holds the sequencer.
module kmeans_clustering #(
    parameter int MAX_POINTS = kmc_pkg::DEF_MAX_POINTS,
    parameter int MAX_K      = kmc_pkg::DEF_MAX_K,
    parameter int MAX_DIM    = kmc_pkg::DEF_MAX_DIM
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [31:0] i_coordinate,
    input  logic        i_last_of_set,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_centroid_value,
    output logic [2:0]  o_cluster_index,
    output logic [2:0]  o_coord_index,
    output logic [1:0]  o_status,
    output logic        o_last,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data
);
    import kmc_pkg::*;

    localparam int DW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int DIMW  = $clog2(MAX_DIM + 1);
    localparam int KW    = $clog2(MAX_K + 1);
    localparam int CIW   = $clog2(MAX_K);
    localparam int PIW   = $clog2(MAX_POINTS);
    localparam int PCW   = $clog2(MAX_POINTS + 1);
    localparam int AW    = PIW + DW;
    localparam int DEPTH = MAX_POINTS * (1 << DW);
    localparam int SUM_W = 32 + PCW;
    localparam int WW    = $clog2(SUM_W + MAX_K + 16);

    typedef enum logic [3:0] {
        S_LOAD, S_CHK, S_ERR, S_SEED, S_CLR, S_PT, S_DIST, S_DW,
        S_ADD, S_UPD, S_UW, S_CONV, S_EMIT, S_SHW
    } t_state;

    t_state        r_state;
    logic [3:0]    r_k_cfg;
    logic [3:0]    r_d_cfg;
    logic [9:0]    r_it_cfg;
    logic [31:0]   r_thr;
    logic [PCW-1:0] r_pc;
    logic [DW-1:0] r_cc;
    logic          r_ovf;
    logic [PIW-1:0] r_p;
    logic [KW-1:0] r_i;
    logic [DW-1:0] r_j;
    logic [9:0]    r_it;
    logic [WW-1:0] r_wait;
    logic [CIW-1:0] r_best;
    t_op           r_op;
    logic [DW-1:0] r_cj;
    logic [CIW-1:0] r_csel;
    logic          r_ov;
    logic [31:0]   r_val;
    logic [2:0]    r_ci;
    logic [2:0]    r_di;
    logic [1:0]    r_st;
    logic          r_last;

    logic [KW-1:0]   eff_k;
    logic [DIMW-1:0] eff_d;
    logic [9:0]      eff_it;
    logic            last_j;
    logic            last_i;
    logic            last_p;
    logic            out_free;
    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    logic [AW-1:0]   ram_raddr;
    logic [PIW-1:0]  rd_row;
    logic [31:0]     ram_rdata;
    t_cmd            cmd;
    t_best           chain [MAX_K+1];
    logic [MAX_DIM-1:0][31:0] cent [MAX_K+1];
    logic [MAX_K-1:0] moved;

    assign eff_k = (r_k_cfg < 4'd2) ? KW'(2)
                 : ((32'(r_k_cfg) > MAX_K) ? KW'(MAX_K) : KW'(r_k_cfg));
    assign eff_d = (r_d_cfg < 4'd1) ? DIMW'(1)
                 : ((32'(r_d_cfg) > MAX_DIM) ? DIMW'(MAX_DIM) : DIMW'(r_d_cfg));
    assign eff_it = (r_it_cfg < 10'd2) ? 10'd2
                  : ((r_it_cfg > 10'd999) ? 10'd999 : r_it_cfg);

    assign last_j   = (DIMW'(r_j) + DIMW'(1)) == eff_d;
    assign last_i   = (r_i + KW'(1)) == eff_k;
    assign last_p   = (PCW'(r_p) + PCW'(1)) == r_pc;
    assign out_free = !r_ov || i_out_ready;

    assign o_in_ready = r_state == S_LOAD;
    assign ram_we     = (r_state == S_LOAD) && i_in_valid && (r_pc < PCW'(MAX_POINTS));
    assign ram_waddr  = {r_pc[PIW-1:0], r_cc};
    assign rd_row     = (r_state == S_SEED) ? PIW'(r_i) : r_p;
    assign ram_raddr  = {rd_row, r_j};

    kmc_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_points (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_coordinate),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign cmd = '{op: r_op, j: 6'(r_cj), sel: 6'(r_csel), data: ram_rdata,
                   k: 7'(eff_k), thr: r_thr};

    assign chain[0]     = '0;
    assign cent[MAX_K]  = '0;

    for (genvar g = 0; g < MAX_K; g++) begin : g_cell
        kmc_cell #(
            .IDX     (g),
            .MAX_DIM (MAX_DIM),
            .SUM_W   (SUM_W),
            .CNT_W   (PCW)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_cmd       (cmd),
            .i_best      (chain[g]),
            .o_best      (chain[g+1]),
            .i_next_cent (cent[g+1]),
            .o_cent      (cent[g]),
            .o_moved     (moved[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_LOAD;
            r_k_cfg  <= RST_CLUSTER_COUNT;
            r_d_cfg  <= RST_DIMENSION;
            r_it_cfg <= RST_MAX_ITER;
            r_thr    <= RST_MOVE_THR;
            r_pc     <= '0;
            r_cc     <= '0;
            r_ovf    <= 1'b0;
            r_ov     <= 1'b0;
            r_op     <= OP_NOP;
        end else begin
            r_op <= OP_NOP;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_CLUSTER_COUNT: r_k_cfg  <= i_cfg_data[3:0];
                    CFG_DIMENSION:     r_d_cfg  <= i_cfg_data[3:0];
                    CFG_MAX_ITER:      r_it_cfg <= i_cfg_data[9:0];
                    CFG_MOVE_THR:      r_thr    <= i_cfg_data;
                endcase
            end
            if (r_ov && i_out_ready) begin
                r_ov <= 1'b0;
            end

            unique case (r_state)
                S_LOAD: begin
                    if (i_in_valid) begin
                        if (r_pc >= PCW'(MAX_POINTS)) begin
                            r_ovf <= 1'b1;
                        end else if ((DIMW'(r_cc) + DIMW'(1)) >= eff_d) begin
                            r_pc <= r_pc + 1'b1;
                            r_cc <= '0;
                        end else begin
                            r_cc <= r_cc + 1'b1;
                        end
                        if (i_last_of_set) begin
                            r_state <= S_CHK;
                        end
                    end
                end
                S_CHK: begin
                    r_i <= '0;
                    r_j <= '0;
                    if (r_ovf || (32'(r_pc) <= 32'(eff_k))) begin
                        r_state <= S_ERR;
                    end else begin
                        r_state <= S_SEED;
                    end
                end
                S_ERR: begin
                    if (out_free) begin
                        r_ov    <= 1'b1;
                        r_val   <= '0;
                        r_ci    <= '0;
                        r_di    <= '0;
                        r_st    <= r_ovf ? ST_OVERFLOW : ST_FEW;
                        r_last  <= 1'b1;
                        r_pc    <= '0;
                        r_cc    <= '0;
                        r_ovf   <= 1'b0;
                        r_state <= S_LOAD;
                    end
                end
                S_SEED: begin
                    r_op   <= OP_SEED;
                    r_cj   <= r_j;
                    r_csel <= CIW'(r_i);
                    if (last_j) begin
                        r_j <= '0;
                        if (last_i) begin
                            r_it    <= '0;
                            r_state <= S_CLR;
                        end else begin
                            r_i <= r_i + 1'b1;
                        end
                    end else begin
                        r_j <= r_j + 1'b1;
                    end
                end
                S_CLR: begin
                    r_op    <= OP_CLR;
                    r_p     <= '0;
                    r_state <= S_PT;
                end
                S_PT: begin
                    r_op    <= OP_DCLR;
                    r_j     <= '0;
                    r_state <= S_DIST;
                end
                S_DIST: begin
                    r_op <= OP_DIST;
                    r_cj <= r_j;
                    if (last_j) begin
                        r_j     <= '0;
                        r_wait  <= WW'(MAX_K + 4);
                        r_state <= S_DW;
                    end else begin
                        r_j <= r_j + 1'b1;
                    end
                end
                S_DW: begin
                    if (r_wait == '0) begin
                        r_best  <= chain[MAX_K].idx[CIW-1:0];
                        r_state <= S_ADD;
                    end else begin
                        r_wait <= r_wait - 1'b1;
                    end
                end
                S_ADD: begin
                    r_op   <= OP_ADD;
                    r_cj   <= r_j;
                    r_csel <= r_best;
                    if (last_j) begin
                        r_j <= '0;
                        if (last_p) begin
                            r_state <= S_UPD;
                        end else begin
                            r_p     <= r_p + 1'b1;
                            r_state <= S_PT;
                        end
                    end else begin
                        r_j <= r_j + 1'b1;
                    end
                end
                S_UPD: begin
                    r_op    <= OP_UPD;
                    r_cj    <= r_j;
                    r_wait  <= WW'(SUM_W + 6);
                    r_state <= S_UW;
                end
                S_UW: begin
                    if (r_wait == '0) begin
                        if (last_j) begin
                            r_j     <= '0;
                            r_state <= S_CONV;
                        end else begin
                            r_j     <= r_j + 1'b1;
                            r_state <= S_UPD;
                        end
                    end else begin
                        r_wait <= r_wait - 1'b1;
                    end
                end
                S_CONV: begin
                    if ((moved == '0) || ((32'(r_it) + 1) >= 32'(eff_it))) begin
                        r_i     <= '0;
                        r_j     <= '0;
                        r_state <= S_EMIT;
                    end else begin
                        r_it    <= r_it + 1'b1;
                        r_state <= S_CLR;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_ov   <= 1'b1;
                        r_val  <= cent[0][r_j];
                        r_ci   <= 3'(r_i);
                        r_di   <= 3'(r_j);
                        r_st   <= ST_OK;
                        r_last <= last_i && last_j;
                        if (last_j) begin
                            r_j <= '0;
                            if (last_i) begin
                                r_pc    <= '0;
                                r_cc    <= '0;
                                r_ovf   <= 1'b0;
                                r_state <= S_LOAD;
                            end else begin
                                r_i     <= r_i + 1'b1;
                                r_op    <= OP_SHIFT;
                                r_state <= S_SHW;
                            end
                        end else begin
                            r_j <= r_j + 1'b1;
                        end
                    end
                end
                S_SHW: begin
                    r_state <= S_EMIT;
                end
            endcase
        end
    end

    assign o_out_valid      = r_ov;
    assign o_centroid_value = r_val;
    assign o_cluster_index  = r_ci;
    assign o_coord_index    = r_di;
    assign o_status         = r_st;
    assign o_last           = r_last;
endmodule
